// ----- sv/ethernet_ipv4_header_parser_defines.svh -----
// assertion macros used by the header parser rtl
`ifndef ETHERNET_IPV4_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_IPV4_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define EIPHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define EIPHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/eiphp_pkg.sv -----
// types, constants and offsets for the ethernet ipv4 header parser
package eiphp_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    // capture length as seen by the checks, clamped to 7 bits
    localparam int LEN_W = 7;
    localparam logic [LEN_W-1:0] LEN_CLAMP = 7'd127;

    localparam logic [LEN_W-1:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [LEN_W-1:0] MIN_CAPTURE  = 7'd34;
    localparam logic [15:0]      ETYPE_IPV4   = 16'h0800;
    localparam logic [3:0]       IP_VERSION_4 = 4'd4;
    localparam logic [3:0]       IHL_MIN      = 4'd5;

    // frame offsets of the latched fields
    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] OFF_ETYPE    = 6'd12;
    localparam logic [POS_W-1:0] OFF_VER_IHL  = 6'd14;
    localparam logic [POS_W-1:0] OFF_TOT_LEN  = 6'd16;
    localparam logic [POS_W-1:0] OFF_FRAG     = 6'd20;
    localparam logic [POS_W-1:0] OFF_TTL      = 6'd22;
    localparam logic [POS_W-1:0] OFF_PROTO    = 6'd23;
    localparam logic [POS_W-1:0] OFF_SRC      = 6'd26;
    localparam logic [POS_W-1:0] OFF_DST      = 6'd30;
    localparam logic [POS_W-1:0] OFF_NONE     = 6'd63;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_IHL_SMALL = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    // header fields as they stand after the current beat
    typedef struct packed {
        logic [LEN_W-1:0] cap_len;
        logic [15:0]      ethertype;
        logic [7:0]       version_ihl;
        logic [15:0]      tot_len;
        logic [15:0]      frag_word;
        logic [7:0]       ttl;
        logic [7:0]       protocol;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
    } t_hdr;

endpackage

// ----- sv/eiphp_capture.sv -----
// byte counter and fixed-offset field latches for the header parser
module eiphp_capture #(
    parameter int COUNT_WIDTH = eiphp_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output eiphp_pkg::t_hdr  o_view
);
    import eiphp_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] PosLimit = COUNT_WIDTH'(64);
    localparam logic [COUNT_WIDTH-1:0] LenLimit = COUNT_WIDTH'(LEN_CLAMP);

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_ver_ihl, n_ver_ihl;
    logic [15:0] r_tot_len, n_tot_len;
    logic [15:0] r_frag, n_frag;
    logic [7:0]  r_ttl, n_ttl;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [POS_W-1:0] pos;
    logic             saturated;

    assign saturated = (r_count == '1);
    // every latch offset is below 64, larger counts map to an unused slot
    assign pos = (r_count < PosLimit) ? r_count[POS_W-1:0] : OFF_NONE;

    always_comb begin
        n_count   = r_count;
        n_etype   = r_etype;
        n_ver_ihl = r_ver_ihl;
        n_tot_len = r_tot_len;
        n_frag    = r_frag;
        n_ttl     = r_ttl;
        n_proto   = r_proto;
        n_src     = r_src;
        n_dst     = r_dst;
        if (!saturated) begin
            n_count = r_count + 1'b1;
            unique case (pos)
                OFF_ETYPE, OFF_ETYPE + 6'd1:        n_etype   = {r_etype[7:0], i_byte};
                OFF_VER_IHL:                        n_ver_ihl = i_byte;
                OFF_TOT_LEN, OFF_TOT_LEN + 6'd1:    n_tot_len = {r_tot_len[7:0], i_byte};
                OFF_FRAG, OFF_FRAG + 6'd1:          n_frag    = {r_frag[7:0], i_byte};
                OFF_TTL:                            n_ttl     = i_byte;
                OFF_PROTO:                          n_proto   = i_byte;
                OFF_SRC, OFF_SRC + 6'd1,
                OFF_SRC + 6'd2, OFF_SRC + 6'd3:     n_src     = {r_src[23:0], i_byte};
                OFF_DST, OFF_DST + 6'd1,
                OFF_DST + 6'd2, OFF_DST + 6'd3:     n_dst     = {r_dst[23:0], i_byte};
                default: ;
            endcase
        end
    end

    always_comb begin
        o_view.cap_len     = (n_count > LenLimit) ? LEN_CLAMP : n_count[LEN_W-1:0];
        o_view.ethertype   = n_etype;
        o_view.version_ihl = n_ver_ihl;
        o_view.tot_len     = n_tot_len;
        o_view.frag_word   = n_frag;
        o_view.ttl         = n_ttl;
        o_view.protocol    = n_proto;
        o_view.src_addr    = n_src;
        o_view.dst_addr    = n_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            // rearm for the next frame
            r_count   <= '0;
            r_etype   <= '0;
            r_ver_ihl <= '0;
            r_tot_len <= '0;
            r_frag    <= '0;
            r_ttl     <= '0;
            r_proto   <= '0;
            r_src     <= '0;
            r_dst     <= '0;
        end else if (i_beat) begin
            r_count   <= n_count;
            r_etype   <= n_etype;
            r_ver_ihl <= n_ver_ihl;
            r_tot_len <= n_tot_len;
            r_frag    <= n_frag;
            r_ttl     <= n_ttl;
            r_proto   <= n_proto;
            r_src     <= n_src;
            r_dst     <= n_dst;
        end
    end

endmodule

// ----- sv/ethernet_ipv4_header_parser.sv -----
// Ethernet/IPv4 header parser: takes one frame byte per beat (wire order, last byte marked)
// and returns one result beat per frame on its last byte, either a reject status with all
// other fields zero or the parsed IPv4 header fields. One byte is accepted every cycle unless
// input is stalled; the byte passes through an input register, then the counter and field
// latches plus the checks load the result register, which drives the result beat. A result
// waiting on i_ready stalls input only when the next byte is also a last byte. The byte
// counter is COUNT_WIDTH bits and saturates; long frames are still judged right.
module ethernet_ipv4_header_parser #(
    parameter int COUNT_WIDTH = eiphp_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [7:0]  o_protocol_number,
    output logic [7:0]  o_time_to_live,
    output logic [15:0] o_packet_length,
    output logic [5:0]  o_header_bytes,
    output logic        o_fragmented,
    output logic [6:0]  o_l4_offset
);
    import eiphp_pkg::*;

    `include "ethernet_ipv4_header_parser_defines.svh"

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [7:0]  r_proto, n_proto;
    logic [7:0]  r_ttl, n_ttl;
    logic [15:0] r_len, n_len;
    logic [5:0]  r_hbytes, n_hbytes;
    logic        r_frag, n_frag;
    logic [6:0]  r_toff, n_toff;

    t_hdr        view;
    logic        out_free;
    logic        consume;
    logic        emit;
    logic [3:0]  ihl;
    logic [5:0]  hbytes;
    logic [6:0]  hdr_end;

    assign out_free = !r_out_valid || i_ready;
    assign consume  = r_in_valid && (!r_in_last || out_free);
    assign emit     = consume && r_in_last;
    assign o_ready  = !r_in_valid || consume;

    eiphp_capture #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (consume),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_view  (view)
    );

    assign ihl     = view.version_ihl[3:0];
    assign hbytes  = {ihl, 2'b00};
    assign hdr_end = ETH_HDR_LEN + {1'b0, hbytes};

    always_comb begin
        priority if (view.cap_len < MIN_CAPTURE) begin
            n_status = ST_SHORT;
        end else if (view.ethertype != ETYPE_IPV4) begin
            n_status = ST_NOT_IPV4;
        end else if (view.version_ihl[7:4] != IP_VERSION_4) begin
            n_status = ST_BAD_VER;
        end else if (ihl < IHL_MIN) begin
            n_status = ST_IHL_SMALL;
        end else if (view.cap_len < hdr_end) begin
            n_status = ST_TRUNC;
        end else begin
            n_status = ST_OK;
        end
    end

    always_comb begin
        n_src    = '0;
        n_dst    = '0;
        n_proto  = '0;
        n_ttl    = '0;
        n_len    = '0;
        n_hbytes = '0;
        n_frag   = 1'b0;
        n_toff   = '0;
        if (n_status == ST_OK) begin
            n_src    = view.src_addr;
            n_dst    = view.dst_addr;
            n_proto  = view.protocol;
            n_ttl    = view.ttl;
            n_len    = view.tot_len;
            n_hbytes = hbytes;
            // more-fragments flag or nonzero offset
            n_frag   = |view.frag_word[13:0];
            n_toff   = hdr_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= n_status;
            r_src    <= n_src;
            r_dst    <= n_dst;
            r_proto  <= n_proto;
            r_ttl    <= n_ttl;
            r_len    <= n_len;
            r_hbytes <= n_hbytes;
            r_frag   <= n_frag;
            r_toff   <= n_toff;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_status              = r_status;
    assign o_source_address      = r_src;
    assign o_destination_address = r_dst;
    assign o_protocol_number     = r_proto;
    assign o_time_to_live        = r_ttl;
    assign o_packet_length       = r_len;
    assign o_header_bytes        = r_hbytes;
    assign o_fragmented          = r_frag;
    assign o_l4_offset           = r_toff;

    `EIPHP_ASSERT_NOW(a_reject_zeroed, r_out_valid && (r_status != ST_OK), (r_src == '0) && (r_dst == '0) && (r_len == '0) && (r_hbytes == '0) && (r_toff == '0) && !r_frag, "reject result carries nonzero fields")
    `EIPHP_ASSERT_NOW(a_ok_offset, r_out_valid && (r_status == ST_OK), (r_hbytes >= 6'd20) && (r_toff == ETH_HDR_LEN + {1'b0, r_hbytes}), "accepted header has inconsistent length")
    `EIPHP_ASSERT_NEXT(a_last_emits, emit, r_out_valid, "last byte produced no result")
    `EIPHP_ASSERT_NOW(a_empty_ready, !r_in_valid, o_ready, "empty input register refuses a byte")
    `EIPHP_ASSERT_NOW(a_no_overwrite, r_out_valid && !i_ready, !emit, "pending result overwritten")

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the ethernet ipv4 header parser
`timescale 1ns / 1ps

module testbench;
    import eiphp_pkg::*;

    // narrow counter so a long frame reaches saturation quickly
    localparam int CNT_W          = 7;
    localparam int CYCLE_LIMIT    = 50000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 400;
    localparam int LONG_FRAME_LEN = (1 << CNT_W) + 2;

    typedef struct packed {
        t_status     status;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [7:0]  ttl;
        logic [15:0] pkt_len;
        logic [5:0]  hdr_len;
        logic        frag;
        logic [6:0]  xport_off;
    } t_hdr_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_ready = 1'b1;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_source_address;
    logic [31:0] o_destination_address;
    logic [7:0]  o_protocol_number;
    logic [7:0]  o_time_to_live;
    logic [15:0] o_packet_length;
    logic [5:0]  o_header_bytes;
    logic        o_fragmented;
    logic [6:0]  o_l4_offset;

    ethernet_ipv4_header_parser #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_frame_byte          (i_frame_byte),
        .i_last_byte           (i_last_byte),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_status              (o_status),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_protocol_number     (o_protocol_number),
        .o_time_to_live        (o_time_to_live),
        .o_packet_length       (o_packet_length),
        .o_header_bytes        (o_header_bytes),
        .o_fragmented          (o_fragmented),
        .o_l4_offset           (o_l4_offset)
    );

    always #4 i_clk = ~i_clk;

    // parser state as the header predictor sees it
    logic [CNT_W-1:0] seen_count = '0;
    logic [15:0]      etype_acc = '0;
    logic [7:0]       ver_ihl_acc = '0;
    logic [15:0]      tot_len_acc = '0;
    logic [15:0]      frag_acc = '0;
    logic [7:0]       ttl_acc = '0;
    logic [7:0]       proto_acc = '0;
    logic [31:0]      src_acc = '0;
    logic [31:0]      dst_acc = '0;

    t_hdr_result pending_headers[$];
    logic [7:0]  frame_buf[$];

    bit idling_on = 1'b1;
    int rx_stall_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int parsed_seen = 0;

    task automatic clear_header_state();
        seen_count  = '0;
        etype_acc   = '0;
        ver_ihl_acc = '0;
        tot_len_acc = '0;
        frag_acc    = '0;
        ttl_acc     = '0;
        proto_acc   = '0;
        src_acc     = '0;
        dst_acc     = '0;
    endtask

    // latch fields from fixed offsets, judge the frame on its last byte
    task automatic parse_frame_byte(input logic [7:0] b, input logic is_last);
        t_hdr_result r;
        int pos;
        int cap;
        int hb;
        pos = int'(seen_count);
        if (seen_count != {CNT_W{1'b1}}) begin
            if (pos == 12 || pos == 13) etype_acc = {etype_acc[7:0], b};
            else if (pos == 14) ver_ihl_acc = b;
            else if (pos == 16 || pos == 17) tot_len_acc = {tot_len_acc[7:0], b};
            else if (pos == 20 || pos == 21) frag_acc = {frag_acc[7:0], b};
            else if (pos == 22) ttl_acc = b;
            else if (pos == 23) proto_acc = b;
            else if (pos >= 26 && pos <= 29) src_acc = {src_acc[23:0], b};
            else if (pos >= 30 && pos <= 33) dst_acc = {dst_acc[23:0], b};
            seen_count = seen_count + 1'b1;
        end
        if (is_last) begin
            cap = int'(seen_count);
            hb = 4 * int'(ver_ihl_acc[3:0]);
            r = '0;
            if (cap < int'(MIN_CAPTURE)) r.status = ST_SHORT;
            else if (etype_acc != ETYPE_IPV4) r.status = ST_NOT_IPV4;
            else if (ver_ihl_acc[7:4] != IP_VERSION_4) r.status = ST_BAD_VER;
            else if (ver_ihl_acc[3:0] < IHL_MIN) r.status = ST_IHL_SMALL;
            else if (cap < int'(ETH_HDR_LEN) + hb) r.status = ST_TRUNC;
            else begin
                r.status    = ST_OK;
                r.src       = src_acc;
                r.dst       = dst_acc;
                r.proto     = proto_acc;
                r.ttl       = ttl_acc;
                r.pkt_len   = tot_len_acc;
                r.hdr_len   = 6'(hb);
                // more-fragments bit or a nonzero offset, the dont-fragment bit is ignored
                r.frag      = |frag_acc[13:0];
                r.xport_off = 7'(int'(ETH_HDR_LEN) + hb);
            end
            pending_headers.push_back(r);
            clear_header_state();
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected 0x%0h got 0x%0h", results_seen, name, want, got);
        end
    endfunction

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin : rx_side
        t_hdr_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_headers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with no frame pending, status %0d", o_status);
            end else begin
                want = pending_headers.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("source_address", want.src, o_source_address);
                check_field("destination_address", want.dst, o_destination_address);
                check_field("protocol_number", 32'(want.proto), 32'(o_protocol_number));
                check_field("time_to_live", 32'(want.ttl), 32'(o_time_to_live));
                check_field("packet_length", 32'(want.pkt_len), 32'(o_packet_length));
                check_field("header_bytes", 32'(want.hdr_len), 32'(o_header_bytes));
                check_field("fragmented", 32'(want.frag), 32'(o_fragmented));
                check_field("l4_offset", 32'(want.xport_off), 32'(o_l4_offset));
                if (want.status == ST_OK) parsed_seen++;
                results_seen++;
            end
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_headers.size());
            $display("ethernet_ipv4_header_parser: mismatch");
            $finish;
        end
    end

    task automatic pause_sender();
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        i_valid      <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= is_last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        parse_frame_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) begin
            pause_sender();
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // fill frame_buf with a captured frame, bytes outside the header fields random
    task automatic build_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                               input logic [15:0] tot_len, input logic [15:0] frag,
                               input logic [7:0] ttl, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] dst,
                               input int cap_len);
        logic [7:0] hdr [0:33];
        for (int i = 0; i < 34; i++) hdr[i] = 8'($urandom);
        {hdr[12], hdr[13]} = etype;
        hdr[14] = ver_ihl;
        {hdr[16], hdr[17]} = tot_len;
        {hdr[20], hdr[21]} = frag;
        hdr[22] = ttl;
        hdr[23] = proto;
        {hdr[26], hdr[27], hdr[28], hdr[29]} = src;
        {hdr[30], hdr[31], hdr[32], hdr[33]} = dst;
        frame_buf.delete();
        for (int i = 0; i < cap_len; i++)
            frame_buf.push_back(i < 34 ? hdr[i] : 8'($urandom));
    endtask

    task automatic random_frame();
        int kind;
        int ihl;
        int cap;
        logic [15:0] etype;
        logic [3:0]  ver;
        logic [15:0] frag;
        kind  = $urandom_range(0, 99);
        etype = ETYPE_IPV4;
        ver   = IP_VERSION_4;
        ihl   = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(5, 15);
        cap   = int'(ETH_HDR_LEN) + 4 * ihl + $urandom_range(0, 20);
        case ($urandom_range(0, 2))
            0: frag = 16'h0000;
            1: frag = 16'h2000 | 16'($urandom_range(0, 1) << 14);
            default: frag = 16'($urandom);
        endcase
        if (kind >= 60 && kind < 68) begin
            ihl = $urandom_range(6, 15);
            cap = $urandom_range(34, int'(ETH_HDR_LEN) + 4 * ihl - 1);
        end else if (kind >= 68 && kind < 74) begin
            ihl = $urandom_range(0, 4);
            cap = $urandom_range(34, 60);
        end else if (kind >= 74 && kind < 80) begin
            do ver = 4'($urandom); while (ver == IP_VERSION_4);
        end else if (kind >= 80 && kind < 86) begin
            do etype = 16'($urandom); while (etype == ETYPE_IPV4);
        end else if (kind >= 86 && kind < 94) begin
            cap = $urandom_range(1, 33);
        end else if (kind >= 94) begin
            // raw noise
            etype = 16'($urandom);
            ver   = 4'($urandom);
            ihl   = $urandom_range(0, 15);
            cap   = $urandom_range(1, 80);
        end
        build_frame(etype, {ver, 4'(ihl)}, 16'($urandom), frag, 8'($urandom), 8'($urandom),
                    $urandom, $urandom, cap);
        send_frame();
    endtask

    task automatic test_directed_frames();
        build_frame(ETYPE_IPV4, 8'h45, 16'hFFFF, 16'h0000, 8'hFF, 8'h00,
                    32'hFFFF_FFFF, 32'h0000_0000, 34);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h45, 16'h0000, 16'hFFFF, 8'h00, 8'hFF,
                    32'h0000_0000, 32'hFFFF_FFFF, 34);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h45, 16'd40, 16'h2000, 8'd64, 8'd6,
                    32'hC0A8_0001, 32'h0A00_0001, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h45, 16'd40, 16'h0001, 8'd1, 8'd17,
                    32'h7F00_0001, 32'hE000_0001, 41);
        send_frame();
        // dont-fragment alone is not a fragment
        build_frame(ETYPE_IPV4, 8'h45, 16'd40, 16'h4000, 8'd128, 8'd1,
                    32'h0102_0304, 32'h0506_0708, 60);
        send_frame();
        // largest header, captured exactly and one byte short
        build_frame(ETYPE_IPV4, 8'h4F, 16'd60, 16'h0000, 8'd9, 8'd17, $urandom, $urandom, 74);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h4F, 16'd60, 16'h0000, 8'd9, 8'd17, $urandom, $urandom, 73);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h40, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h44, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h65, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'hF5, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(16'h86DD, 8'h45, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(16'h0008, 8'h45, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h45, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 33);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h45, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 1);
        send_frame();
        // check priority: short beats ethertype, ethertype beats version, version beats ihl
        build_frame(16'h0806, 8'h45, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 20);
        send_frame();
        build_frame(16'h0806, 8'h60, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h60, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 40);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h43, 16'd20, 16'h0000, 8'd9, 8'd6, $urandom, $urandom, 34);
        send_frame();
    endtask

    // consecutive last bytes make the parser back-pressure whenever a result is stalled
    task automatic test_single_byte_frames();
        for (int i = 0; i < 16; i++) begin
            frame_buf.delete();
            frame_buf.push_back(8'($urandom));
            send_frame();
        end
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int n;
        start_bytes = bytes_sent;
        n = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            random_frame();
            n++;
            if (n % 5 == 0) wait_drain();
        end
    endtask

    // counter saturation, then a normal frame to see the state clear, then random frames
    task automatic test_long_frame();
        build_frame(ETYPE_IPV4, 8'h46, 16'hABCD, 16'h1FFF, 8'd200, 8'd47,
                    32'hDEAD_BEEF, 32'h0BAD_F00D, LONG_FRAME_LEN);
        send_frame();
        build_frame(ETYPE_IPV4, 8'h45, 16'd34, 16'h0000, 8'd3, 8'd17, $urandom, $urandom, 34);
        send_frame();
        for (int i = 0; i < 6; i++) random_frame();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_single_byte_frames();
        test_random_traffic();
        wait_drain();
        idling_on = 1'b0;
        test_long_frame();
        wait_drain();

        $display("sent %0d frames in %0d bytes, checked %0d results (%0d parsed, %0d rejected)",
                 frames_sent, bytes_sent, results_seen, parsed_seen, results_seen - parsed_seen);
        $display("included a %0d-byte frame past byte counter saturation", LONG_FRAME_LEN);
        if (mismatches == 0 && pending_headers.size() == 0) begin
            $display("ethernet_ipv4_header_parser: match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_headers.size());
            $display("ethernet_ipv4_header_parser: mismatch");
        end
        $finish;
    end

endmodule

// ----- ethernet_ipv4_header_parser.f -----
+incdir+sv
sv/eiphp_pkg.sv
sv/eiphp_capture.sv
sv/ethernet_ipv4_header_parser.sv
dv/testbench.sv
